@@ src/lpi_pkg.sv @@
`default_nettype none
package lpi_pkg;

    localparam int COORD_FRAC_BITS = 16;
    localparam int COORD_WIDTH     = 32;
    localparam int CW   = COORD_WIDTH;
    localparam int FB   = COORD_FRAC_BITS;
    localparam int FW   = 32;
    localparam int DW   = 2 * CW + 2;
    localparam int NW   = 2 * CW + 3;
    localparam int ADW  = 2 * CW;
    localparam int ANW  = 2 * CW + 2 + FB;
    localparam int QW   = CW + 1;
    localparam int CMPW = 3 * CW + FB + 3;
    localparam int IN_W  = 6 * FW;
    localparam int OUT_W = 104;
    localparam int CFG_IDX_W = 3;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW = 2;
    localparam logic [FW-1:0] NORMAL_Z_RESET  = 32'h0001_0000;
    localparam logic [FW-1:0] THRESHOLD_RESET = 32'd4295;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PLANE_PX,
        REG_PLANE_PY,
        REG_PLANE_PZ,
        REG_NORMAL_X,
        REG_NORMAL_Y,
        REG_NORMAL_Z,
        REG_THRESHOLD
    } reg_idx_t;

    typedef struct packed {
        logic [2:0][CW-1:0] pp;
        logic [2:0][CW-1:0] nv;
        logic [FW-1:0]      thr;
    } cfg_t;

    typedef struct packed {
        logic               par;
        logic               neg;
        logic [ANW-1:0]     an;
        logic [ADW-1:0]     ad;
        logic [2:0][CW-1:0] lp;
        logic [2:0][CW-1:0] dv;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage
`default_nettype wire

@@ src/lpi_front.sv @@
`default_nettype none
module lpi_front (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire lpi_pkg::cfg_t           cfg,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [lpi_pkg::IN_W-1:0] s_data,
    output logic                         push,
    output lpi_pkg::item_t               push_item,
    input  wire lpi_pkg::fifo_stat_t     stat
);
    localparam int CW  = lpi_pkg::CW;
    localparam int FW  = lpi_pkg::FW;
    localparam int DW  = lpi_pkg::DW;
    localparam int NW  = lpi_pkg::NW;
    localparam int ADW = lpi_pkg::ADW;
    localparam int FB  = lpi_pkg::FB;

    logic en;
    logic signed [CW-1:0]   lp_in [3];
    logic signed [CW-1:0]   dv_in [3];
    logic signed [CW-1:0]   nv_s  [3];
    logic signed [CW:0]     diff  [3];
    logic signed [2*CW-1:0] pd    [3];
    logic signed [2*CW:0]   pn    [3];

    logic                   v1_reg, v2_reg, v3_reg;
    logic [2:0][CW-1:0]     lp1_reg, dv1_reg, lp2_reg, dv2_reg;
    logic signed [2*CW-1:0] pd1_reg [3];
    logic signed [2*CW:0]   pn1_reg [3];
    logic signed [DW-1:0]   den2_reg;
    logic signed [NW-1:0]   num2_reg;
    lpi_pkg::item_t         item3_reg, item3_next;
    logic signed [DW-1:0]   den_abs;
    logic signed [NW-1:0]   num_abs;

    assign en      = !(v3_reg && stat.full);
    assign s_ready = en;
    assign push    = v3_reg && !stat.full;
    assign push_item = item3_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            lp_in[i] = s_data[i*FW +: CW];
            dv_in[i] = s_data[(3+i)*FW +: CW];
            nv_s[i]  = cfg.nv[i];
            diff[i]  = $signed({cfg.pp[i][CW-1], cfg.pp[i]}) - $signed({lp_in[i][CW-1], lp_in[i]});
            pd[i]    = dv_in[i] * nv_s[i];
            pn[i]    = diff[i] * nv_s[i];
        end
    end

    always_comb begin
        den_abs = den2_reg[DW-1] ? -den2_reg : den2_reg;
        num_abs = num2_reg[NW-1] ? -num2_reg : num2_reg;
        item3_next.neg = den2_reg[DW-1] ^ num2_reg[NW-1];
        item3_next.ad  = den_abs[ADW-1:0];
        item3_next.an  = {num_abs[NW-2:0], {FB{1'b0}}};
        item3_next.par = (den_abs[ADW-1:0] == '0) || (den_abs[ADW-1:0] < ADW'(cfg.thr));
        item3_next.lp  = lp2_reg;
        item3_next.dv  = dv2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                lp1_reg[i] <= lp_in[i];
                dv1_reg[i] <= dv_in[i];
                pd1_reg[i] <= pd[i];
                pn1_reg[i] <= pn[i];
            end
            den2_reg <= DW'(pd1_reg[0]) + DW'(pd1_reg[1]) + DW'(pd1_reg[2]);
            num2_reg <= NW'(pn1_reg[0]) + NW'(pn1_reg[1]) + NW'(pn1_reg[2]);
            lp2_reg  <= lp1_reg;
            dv2_reg  <= dv1_reg;
            item3_reg <= item3_next;
        end
    end

endmodule
`default_nettype wire

@@ src/lpi_fifo.sv @@
`default_nettype none
module lpi_fifo (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push,
    input  wire lpi_pkg::item_t      push_item,
    input  wire logic                pop,
    output lpi_pkg::item_t           pop_item,
    output lpi_pkg::fifo_stat_t      stat
);
    localparam int AW = lpi_pkg::FIFO_AW;
    localparam int DEPTH = lpi_pkg::FIFO_DEPTH;

    lpi_pkg::item_t mem_reg [DEPTH];
    logic [AW-1:0]  wptr_reg, rptr_reg;
    logic [AW:0]    cnt_reg;

    assign stat.full  = (cnt_reg == (AW+1)'(DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign pop_item   = mem_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (push) wptr_reg <= wptr_reg + 1'b1;
            if (pop)  rptr_reg <= rptr_reg + 1'b1;
            if (push && !pop) cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push) cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wptr_reg] <= push_item;
    end

endmodule
`default_nettype wire

@@ src/lpi_back.sv @@
`default_nettype none
module lpi_back (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire lpi_pkg::fifo_stat_t       stat,
    output logic                           pop,
    input  wire lpi_pkg::item_t            pop_item,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [lpi_pkg::OUT_W-1:0]      m_data
);
    localparam int CW   = lpi_pkg::CW;
    localparam int FB   = lpi_pkg::FB;
    localparam int FW   = lpi_pkg::FW;
    localparam int ADW  = lpi_pkg::ADW;
    localparam int ANW  = lpi_pkg::ANW;
    localparam int QW   = lpi_pkg::QW;
    localparam int CMPW = lpi_pkg::CMPW;
    localparam int SW   = 2 * CW - FB + 1;
    localparam int OUT_W = lpi_pkg::OUT_W;
    localparam logic [QW-1:0] LIM = QW'(1) << (CW - 1);
    localparam logic signed [CW-1:0] TMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] TMIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [SW-1:0] SMAX = SW'(TMAX);
    localparam logic signed [SW-1:0] SMIN = SW'(TMIN);

    typedef struct packed {
        logic               par;
        logic               neg;
        logic               ovq;
        logic [ADW-1:0]     r;
        logic [QW-1:0]      q;
        logic [QW-1:0]      anl;
        logic [ADW-1:0]     ad;
        logic [2:0][CW-1:0] lp;
        logic [2:0][CW-1:0] dv;
    } div_t;

    function automatic div_t div_step(input div_t d);
        div_t           o;
        logic [ADW:0]   rs;
        logic [ADW:0]   diff;
        o    = d;
        rs   = {d.r, d.anl[QW-1]};
        diff = rs - {1'b0, d.ad};
        if (rs >= {1'b0, d.ad}) begin
            o.r = diff[ADW-1:0];
            o.q = {d.q[QW-2:0], 1'b1};
        end else begin
            o.r = rs[ADW-1:0];
            o.q = {d.q[QW-2:0], 1'b0};
        end
        o.anl = {d.anl[QW-2:0], 1'b0};
        return o;
    endfunction

    logic en;
    logic                   v0_reg;
    lpi_pkg::item_t         item0_reg;
    logic                   dvld_reg [QW+1];
    div_t                   dst_reg  [QW+1];
    div_t                   dst0_next;

    logic                   vt_reg, vm_reg, vo_reg;
    logic signed [CW-1:0]   t_reg, t_next;
    logic                   ovt_reg, ovt_next, part_reg, parm_reg, ovm_reg;
    logic [2:0][CW-1:0]     lpt_reg, dvt_reg, lpm_reg;
    logic signed [2*CW-1:0] prod_reg [3];
    logic signed [2*CW-1:0] prod     [3];
    logic [OUT_W-1:0]       od_reg, od_next;
    div_t                   dl;

    assign en      = !vo_reg || m_ready;
    assign pop     = en && !stat.empty;
    assign m_valid = vo_reg;
    assign m_data  = od_reg;
    assign dl      = dst_reg[QW];

    always_comb begin
        dst0_next.par = item0_reg.par;
        dst0_next.neg = item0_reg.neg;
        dst0_next.ovq = CMPW'(item0_reg.an) >= (CMPW'(item0_reg.ad) << QW);
        dst0_next.r   = ADW'(item0_reg.an[ANW-1:QW]);
        dst0_next.q   = '0;
        dst0_next.anl = item0_reg.an[QW-1:0];
        dst0_next.ad  = item0_reg.ad;
        dst0_next.lp  = item0_reg.lp;
        dst0_next.dv  = item0_reg.dv;
    end

    always_comb begin
        ovt_next = 1'b0;
        if (!dl.neg) begin
            if (dl.ovq || dl.q > LIM - 1'b1) begin
                ovt_next = 1'b1;
                t_next   = TMAX;
            end else begin
                t_next = dl.q[CW-1:0];
            end
        end else begin
            if (dl.ovq || dl.q > LIM) begin
                ovt_next = 1'b1;
                t_next   = TMIN;
            end else begin
                t_next = -$signed(dl.q[CW-1:0]);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            prod[i] = t_reg * $signed(dvt_reg[i]);
        end
    end

    always_comb begin
        logic signed [2*CW-1:0] sh;
        logic signed [SW-1:0]   s;
        logic [2:0][CW-1:0]     c;
        logic                   ov;
        ov = ovm_reg;
        for (int i = 0; i < 3; i++) begin
            sh = prod_reg[i] >>> FB;
            s  = SW'(sh) + SW'($signed(lpm_reg[i]));
            if (s > SMAX) begin
                c[i] = TMAX;
                ov   = 1'b1;
            end else if (s < SMIN) begin
                c[i] = TMIN;
                ov   = 1'b1;
            end else begin
                c[i] = s[CW-1:0];
            end
        end
        od_next = '0;
        if (!parm_reg) begin
            od_next[0] = 1'b1;
            for (int i = 0; i < 3; i++) begin
                od_next[1 + i*FW +: FW] = FW'($signed(c[i]));
            end
            od_next[1 + 3*FW] = ov;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            for (int k = 0; k <= QW; k++) dvld_reg[k] <= 1'b0;
            vt_reg <= 1'b0;
            vm_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else if (en) begin
            v0_reg      <= !stat.empty;
            dvld_reg[0] <= v0_reg;
            for (int k = 0; k < QW; k++) dvld_reg[k+1] <= dvld_reg[k];
            vt_reg <= dvld_reg[QW];
            vm_reg <= vt_reg;
            vo_reg <= vm_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            item0_reg  <= pop_item;
            dst_reg[0] <= dst0_next;
            for (int k = 0; k < QW; k++) dst_reg[k+1] <= div_step(dst_reg[k]);
            t_reg    <= t_next;
            ovt_reg  <= ovt_next;
            part_reg <= dl.par;
            lpt_reg  <= dl.lp;
            dvt_reg  <= dl.dv;
            for (int i = 0; i < 3; i++) prod_reg[i] <= prod[i];
            ovm_reg  <= ovt_reg;
            parm_reg <= part_reg;
            lpm_reg  <= lpt_reg;
            od_reg   <= od_next;
        end
    end

endmodule
`default_nettype wire

@@ src/line_plane_intersection_top.sv @@
// Channel  Direction  Handshake              Payload
// s_       in         s_tvalid / s_tready    line point and direction, 192 bits
// m_       out        m_tvalid / m_tready    hit, hit point, overflow, 104 bits
// cfg_     in         cfg_valid / cfg_ready  register index and 32-bit data
// One item enters per cycle while s_tready is high, and items overlap in the
// 33-step division pipe of the back end.
// A 4-entry queue separates the product front end from the division back end.
// The back end stalls as a whole while the output register holds an untaken item.
// Reset is synchronous on aresetn and loads the default plane z = 0, normal +z.
`default_nettype none
module line_plane_intersection_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // line_px, line_py, line_pz, dir_x, dir_y, dir_z
    input  wire logic [lpi_pkg::IN_W-1:0]      s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // hit, hit_x, hit_y, hit_z, overflow, zero fill
    output logic [lpi_pkg::OUT_W-1:0]          m_tdata,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [lpi_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lpi_pkg::FW-1:0]        cfg_data
);
    localparam int CW = lpi_pkg::CW;
    localparam int FW = lpi_pkg::FW;

    logic [FW-1:0] px_reg, py_reg, pz_reg, nx_reg, ny_reg, nz_reg, thr_reg;
    lpi_pkg::cfg_t       cfg;
    lpi_pkg::item_t      push_item, pop_item;
    lpi_pkg::fifo_stat_t fstat;
    logic                push, pop;

    assign cfg_ready = 1'b1;
    assign cfg.pp  = {pz_reg[CW-1:0], py_reg[CW-1:0], px_reg[CW-1:0]};
    assign cfg.nv  = {nz_reg[CW-1:0], ny_reg[CW-1:0], nx_reg[CW-1:0]};
    assign cfg.thr = thr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            px_reg  <= '0;
            py_reg  <= '0;
            pz_reg  <= '0;
            nx_reg  <= '0;
            ny_reg  <= '0;
            nz_reg  <= lpi_pkg::NORMAL_Z_RESET;
            thr_reg <= lpi_pkg::THRESHOLD_RESET;
        end else if (cfg_valid) begin
            case (lpi_pkg::reg_idx_t'(cfg_index))
                lpi_pkg::REG_PLANE_PX:  px_reg  <= cfg_data;
                lpi_pkg::REG_PLANE_PY:  py_reg  <= cfg_data;
                lpi_pkg::REG_PLANE_PZ:  pz_reg  <= cfg_data;
                lpi_pkg::REG_NORMAL_X:  nx_reg  <= cfg_data;
                lpi_pkg::REG_NORMAL_Y:  ny_reg  <= cfg_data;
                lpi_pkg::REG_NORMAL_Z:  nz_reg  <= cfg_data;
                lpi_pkg::REG_THRESHOLD: thr_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    lpi_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .s_data    (s_tdata),
        .push      (push),
        .push_item (push_item),
        .stat      (fstat)
    );

    lpi_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .stat      (fstat)
    );

    lpi_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .stat     (fstat),
        .pop      (pop),
        .pop_item (pop_item),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_data   (m_tdata)
    );

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[lpi_pkg::OUT_W-1:1] == '0)
        else $error("miss result carries nonzero fields");

    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> fstat.full)
        else $error("input stalled while queue has room");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule
`default_nettype wire
